>>> rtl/mtwg_pkg.sv
// mtwg_pkg: shared constants and types of the mersenne twister word generator
// no dependencies; used by mtwg_ram, mtwg_twist and the top level

package mtwg_pkg;

    localparam int unsigned TABLE_DEPTH  = 624;
    localparam int unsigned ADDR_W       = 10;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned DISCARD_COUNT = 37;
    localparam int unsigned DISC_W       = 6;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    // index at which the far tap wraps back to the start of the table
    localparam logic [ADDR_W-1:0] FAR_WRAP  = ADDR_W'(TABLE_DEPTH - TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_UP    = ADDR_W'(TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_DOWN  = ADDR_W'(TABLE_DEPTH - TWIST_OFFSET);
    localparam logic [DISC_W-1:0] LAST_DISC = DISC_W'(DISCARD_COUNT - 1);

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] UPPER_BIT    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS   = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
    localparam int unsigned       INIT_SHIFT   = 30;
    localparam logic [WORD_W-1:0] RESET_SEED   = 32'd5489;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

    // opcode carried in tuser
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // request from the sequencer to the state table memory
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
    } ram_req_t;

endpackage

>>> rtl/mtwg_ram.sv
// mtwg_ram: state table memory, one write port and two registered read ports
// depends on mtwg_pkg

module mtwg_ram (
    input  logic                          clk,
    input  mtwg_pkg::ram_req_t            req,
    output logic [mtwg_pkg::WORD_W-1:0]   rd_data_a,
    output logic [mtwg_pkg::WORD_W-1:0]   rd_data_b
);

    logic [mtwg_pkg::WORD_W-1:0] mem [mtwg_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_a <= mem[req.rd_addr_a];
            rd_data_b <= mem[req.rd_addr_b];
        end
    end

endmodule

>>> rtl/mtwg_twist.sv
// mtwg_twist: twist of one table element and tempering of the new word
// depends on mtwg_pkg

module mtwg_twist (
    input  logic [mtwg_pkg::WORD_W-1:0] cur_word,
    input  logic [mtwg_pkg::WORD_W-1:0] nxt_word,
    input  logic [mtwg_pkg::WORD_W-1:0] far_word,
    output logic [mtwg_pkg::WORD_W-1:0] new_word,
    output logic [mtwg_pkg::WORD_W-1:0] tempered
);

    logic [mtwg_pkg::WORD_W-1:0] y;
    logic [mtwg_pkg::WORD_W-1:0] t1;
    logic [mtwg_pkg::WORD_W-1:0] t2;
    logic [mtwg_pkg::WORD_W-1:0] t3;

    always_comb
    begin
        y        = (cur_word & mtwg_pkg::UPPER_BIT) | (nxt_word & mtwg_pkg::LOWER_BITS);
        new_word = far_word ^ (y >> 1) ^ (y[0] ? mtwg_pkg::TWIST_MATRIX : '0);
        t1       = new_word ^ (new_word >> 11);
        t2       = t1 ^ ((t1 << 7) & mtwg_pkg::TEMPER_B);
        t3       = t2 ^ ((t2 << 15) & mtwg_pkg::TEMPER_C);
        tempered = t3 ^ (t3 >> 18);
    end

endmodule

>>> rtl/mersenne_twister_word_generator.sv
// mersenne_twister_word_generator: mt19937 draw / reseed engine, top level
// depends on mtwg_pkg, mtwg_ram, mtwg_twist

// The block holds the 624-word mt19937 state in one memory with two
// registered read ports and twists each element lazily, just before it is
// drawn. A draw beat (tuser = 0) first reads the next and far taps from
// the memory, then twists, writes back and tempers; the input stays closed
// until the twist is done, and the twist waits while the output register
// holds a word that is not taken. The word at the read point is kept in
// a register, so no third read port is needed. A reseed beat (tuser = 1,
// seed in tdata) gives no output beat and keeps the input closed while it
// writes the seed word, fills the other 623 words (multiply, then add and
// write) and runs the 37 discarded draws. After reset the same sequence
// runs with seed 5489 before the first beat is taken. The output register
// lets a new input beat be taken while a word still waits.

module mersenne_twister_word_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // seed_value[31:0]
    input  logic                        s_axis_tuser,   // opcode[0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata    // random_word[31:0]
);

    typedef enum logic [2:0] {
        ST_FILL_SEED,
        ST_FILL_MUL,
        ST_FILL_ADD,
        ST_DISC_RD,
        ST_TWIST,
        ST_IDLE
    } state_t;

    state_t                        state_reg;
    logic [mtwg_pkg::ADDR_W-1:0]   rd_idx_reg;     // next element to twist and draw
    logic [mtwg_pkg::ADDR_W-1:0]   fill_idx_reg;
    logic [mtwg_pkg::DISC_W-1:0]   disc_cnt_reg;
    logic                          disc_reg;       // current twist is a discarded draw
    logic [mtwg_pkg::WORD_W-1:0]   prev_reg;       // last word written by the fill
    logic [mtwg_pkg::WORD_W-1:0]   prod_reg;
    logic [mtwg_pkg::WORD_W-1:0]   cur_reg;        // table word at rd_idx_reg
    logic                          out_valid_reg;
    logic [mtwg_pkg::WORD_W-1:0]   out_data_reg;

    mtwg_pkg::ram_req_t            ram_req;
    logic [mtwg_pkg::WORD_W-1:0]   rd_data_a;
    logic [mtwg_pkg::WORD_W-1:0]   rd_data_b;
    logic [mtwg_pkg::WORD_W-1:0]   new_word;
    logic [mtwg_pkg::WORD_W-1:0]   tempered;

    logic                          in_fire;
    logic                          draw_fire;
    logic                          twist_go;
    logic                          out_load;
    logic [mtwg_pkg::ADDR_W-1:0]   nxt_addr;
    logic [mtwg_pkg::ADDR_W-1:0]   far_addr;
    logic [mtwg_pkg::ADDR_W-1:0]   rd_idx_next;
    logic [mtwg_pkg::WORD_W-1:0]   mix_word;
    logic [mtwg_pkg::WORD_W-1:0]   fill_word;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign draw_fire     = in_fire && (s_axis_tuser == mtwg_pkg::OP_DRAW);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a real draw waits for room in the output register, a discard never does
    assign twist_go = (state_reg == ST_TWIST) && (disc_reg || !out_valid_reg || m_axis_tready);
    // a real draw loads the output register
    assign out_load = twist_go && !disc_reg;

    always_comb
    begin
        nxt_addr    = (rd_idx_reg == mtwg_pkg::LAST_ADDR) ? '0 : rd_idx_reg + 1'b1;
        far_addr    = (rd_idx_reg < mtwg_pkg::FAR_WRAP) ? rd_idx_reg + mtwg_pkg::FAR_UP
                                                        : rd_idx_reg - mtwg_pkg::FAR_DOWN;
        rd_idx_next = nxt_addr;
        mix_word    = prev_reg ^ (prev_reg >> mtwg_pkg::INIT_SHIFT);
        fill_word   = prod_reg + {{(mtwg_pkg::WORD_W - mtwg_pkg::ADDR_W){1'b0}}, fill_idx_reg};
    end

    // memory requests
    always_comb
    begin
        ram_req           = '0;
        ram_req.rd_en     = draw_fire || (state_reg == ST_DISC_RD);
        ram_req.rd_addr_a = nxt_addr;
        ram_req.rd_addr_b = far_addr;
        case (state_reg)
            ST_FILL_SEED:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = '0;
                ram_req.wr_data = prev_reg;
            end
            ST_FILL_ADD:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = fill_idx_reg;
                ram_req.wr_data = fill_word;
            end
            ST_TWIST:
            begin
                ram_req.wr_en   = twist_go;
                ram_req.wr_addr = rd_idx_reg;
                ram_req.wr_data = new_word;
            end
            default:
            begin
                ram_req.wr_en = 1'b0;
            end
        endcase
    end

    mtwg_ram u_ram (
        .clk       (clk),
        .req       (ram_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // element at the read point: cached current word, next word, far tap
    mtwg_twist u_twist (
        .cur_word (cur_reg),
        .nxt_word (rd_data_a),
        .far_word (rd_data_b),
        .new_word (new_word),
        .tempered (tempered)
    );

    // sequencer, fill datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL_SEED;
            rd_idx_reg    <= '0;
            fill_idx_reg  <= '0;
            disc_cnt_reg  <= '0;
            disc_reg      <= 1'b0;
            prev_reg      <= mtwg_pkg::RESET_SEED;
            prod_reg      <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= tempered;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_FILL_SEED:
                begin
                    cur_reg      <= prev_reg;
                    fill_idx_reg <= {{(mtwg_pkg::ADDR_W-1){1'b0}}, 1'b1};
                    state_reg    <= ST_FILL_MUL;
                end
                ST_FILL_MUL:
                begin
                    prod_reg  <= mix_word * mtwg_pkg::INIT_MULT;
                    state_reg <= ST_FILL_ADD;
                end
                ST_FILL_ADD:
                begin
                    prev_reg <= fill_word;
                    if (fill_idx_reg == mtwg_pkg::LAST_ADDR)
                    begin
                        rd_idx_reg   <= '0;
                        disc_cnt_reg <= '0;
                        disc_reg     <= 1'b1;
                        state_reg    <= ST_DISC_RD;
                    end
                    else
                    begin
                        fill_idx_reg <= fill_idx_reg + 1'b1;
                        state_reg    <= ST_FILL_MUL;
                    end
                end
                ST_DISC_RD:
                begin
                    state_reg <= ST_TWIST;
                end
                ST_TWIST:
                begin
                    if (twist_go)
                    begin
                        cur_reg    <= rd_data_a;
                        rd_idx_reg <= rd_idx_next;
                        if (disc_reg)
                        begin
                            disc_cnt_reg <= disc_cnt_reg + 1'b1;
                            if (disc_cnt_reg == mtwg_pkg::LAST_DISC)
                            begin
                                disc_reg  <= 1'b0;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_DISC_RD;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tuser == mtwg_pkg::OP_RESEED)
                        begin
                            prev_reg  <= s_axis_tdata;
                            state_reg <= ST_FILL_SEED;
                        end
                        else
                        begin
                            disc_reg  <= 1'b0;
                            state_reg <= ST_TWIST;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> test/mtwg_word_checker.sv
`timescale 1ns / 100ps
// mtwg_word_checker: watches the draw/reseed and word channels of the mt19937
// word generator, predicts every drawn word and compares it
// depends on mtwg_pkg

module mtwg_word_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // seed_value[31:0]
    input  logic        s_axis_tuser,   // opcode[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // random_word[31:0]
    output int          error_count,
    output int          words_pending,
    output int          words_checked,
    output int          reseed_count,
    output int          regen_count
);

    logic [mtwg_pkg::WORD_W-1:0] mt_table [mtwg_pkg::TABLE_DEPTH];
    int unsigned                 mt_index;
    logic [mtwg_pkg::WORD_W-1:0] expected_words [$];
    logic [mtwg_pkg::WORD_W-1:0] oldest_word;
    logic [mtwg_pkg::WORD_W-1:0] drawn_word;

    // regenerate the whole table in place
    function automatic void twist_mt_table();
        int unsigned                 k;
        logic [mtwg_pkg::WORD_W-1:0] y;
        for (k = 0; k < mtwg_pkg::TABLE_DEPTH; k++)
        begin
            y = (mt_table[k] & mtwg_pkg::UPPER_BIT)
              | (mt_table[(k + 1) % mtwg_pkg::TABLE_DEPTH] & mtwg_pkg::LOWER_BITS);
            mt_table[k] = mt_table[(k + mtwg_pkg::TWIST_OFFSET) % mtwg_pkg::TABLE_DEPTH]
                        ^ (y >> 1) ^ (y[0] ? mtwg_pkg::TWIST_MATRIX : '0);
        end
        mt_index = 0;
        regen_count++;
    endfunction

    function automatic logic [mtwg_pkg::WORD_W-1:0] draw_mt_word();
        logic [mtwg_pkg::WORD_W-1:0] y;
        if (mt_index >= mtwg_pkg::TABLE_DEPTH)
            twist_mt_table();
        y = mt_table[mt_index];
        mt_index++;
        y ^= y >> 11;
        y ^= (y << 7) & mtwg_pkg::TEMPER_B;
        y ^= (y << 15) & mtwg_pkg::TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    // linear fill, then the discarded draws
    function automatic void reseed_mt_table(input logic [mtwg_pkg::WORD_W-1:0] seed);
        int unsigned                 i;
        logic [mtwg_pkg::WORD_W-1:0] prev;
        mt_table[0] = seed;
        for (i = 1; i < mtwg_pkg::TABLE_DEPTH; i++)
        begin
            prev = mt_table[i-1];
            mt_table[i] = mtwg_pkg::INIT_MULT * (prev ^ (prev >> mtwg_pkg::INIT_SHIFT))
                        + mtwg_pkg::WORD_W'(i);
        end
        mt_index = mtwg_pkg::TABLE_DEPTH;
        for (i = 0; i < mtwg_pkg::DISCARD_COUNT; i++)
            void'(draw_mt_word());
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < 20)
            $display("%0t ns mismatch: %s, expected %08h got %08h", $time, what, want, got);
        error_count++;
    endtask

    // model back at the reset seeding while reset is held; output beat
    // checked before the input beat of the same edge is predicted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            error_count   = 0;
            words_pending = 0;
            words_checked = 0;
            reseed_count  = 0;
            expected_words.delete();
            reseed_mt_table(mtwg_pkg::RESET_SEED);
            regen_count   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("random_word with no draw pending", '0, m_axis_tdata);
                else
                begin
                    oldest_word = expected_words.pop_front();
                    if (m_axis_tdata !== oldest_word)
                        report_mismatch("random_word", oldest_word, m_axis_tdata);
                    words_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == mtwg_pkg::OP_RESEED)
                begin
                    reseed_mt_table(s_axis_tdata);
                    reseed_count++;
                end
                else
                begin
                    drawn_word     = draw_mt_word();
                    expected_words = {expected_words, drawn_word};
                end
            end
            words_pending = expected_words.size();
        end
    end

endmodule

>>> test/mersenne_twister_word_generator_tb.sv
`timescale 1ns / 100ps
// mersenne_twister_word_generator_tb: drives draw and reseed beats into the
// mt19937 word generator and gives the verdict
// depends on mtwg_pkg, mtwg_word_checker and the generator rtl

module mersenne_twister_word_generator_tb;

    localparam int RANDOM_BEATS  = 1150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 250;
    // a reseed pass keeps the block busy with no output beat
    localparam int SETTLE_CYCLES = 1400;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // seed_value[31:0]
    logic        s_axis_tuser;     // opcode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // random_word[31:0]

    int   error_count;
    int   words_pending;
    int   words_checked;
    int   reseed_count;
    int   regen_count;
    int   beats_sent;
    int   cycle_count;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_request;

    mersenne_twister_word_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor and comparator live beside the block
    mtwg_word_checker word_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .reseed_count  (reseed_count),
        .regen_count   (regen_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: covers the startup seeding pass, every reseed and all stalls
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d words still pending",
                         cycle_count, words_pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // offer one beat and hold it until the block takes it
    task automatic send_beat(input logic op, input logic [31:0] seed);
        s_axis_tuser  <= op;
        s_axis_tdata  <= seed;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // random burst of empty cycles on the input side
    task automatic sender_gap();
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // idle density per stretch: none, light or heavy
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 30;
        endcase
    endfunction

    // receiver: random stall bursts, plus one long hold-off so that the
    // output register fills and the block closes its input
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int n;
        beats_sent    = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mtwg_pkg::OP_DRAW;
        hold_request  <= 1'b0;
        tx_idle_pct   <= 0;
        rx_idle_pct   <= 10;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: words straight from the reset seeding, seed field
        // extremes on draws (ignored there), reseeds with zero, all ones,
        // the reset seed and a top-and-bottom bit pattern
        send_beat(mtwg_pkg::OP_DRAW, 32'h0000_0000);
        send_beat(mtwg_pkg::OP_DRAW, 32'hFFFF_FFFF);
        send_beat(mtwg_pkg::OP_DRAW, $urandom());
        send_beat(mtwg_pkg::OP_RESEED, 32'h0000_0000);
        repeat (3) send_beat(mtwg_pkg::OP_DRAW, $urandom());
        send_beat(mtwg_pkg::OP_RESEED, 32'hFFFF_FFFF);
        repeat (3) send_beat(mtwg_pkg::OP_DRAW, $urandom());
        send_beat(mtwg_pkg::OP_RESEED, mtwg_pkg::RESET_SEED);
        repeat (2) send_beat(mtwg_pkg::OP_DRAW, $urandom());
        send_beat(mtwg_pkg::OP_RESEED, 32'h8000_0001);
        repeat (3) send_beat(mtwg_pkg::OP_DRAW, $urandom());

        // random: long draw runs so the table gets used up and regenerated,
        // with occasional reseeds from random seeds later on
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 100 == 0)
            begin
                // the tail of the run goes at full rate on both sides
                tx_idle_pct <= (n >= 1000) ? 0 : pick_idle_pct();
                rx_idle_pct <= (n >= 1000) ? 0 : pick_idle_pct();
            end
            if (n == 300)
                hold_request <= 1'b1;
            if (n == 800)
            begin
                // drain pause: nothing offered until every word is back
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                wait (words_pending == 0);
                @(posedge clk);
            end
            if (n == 700 || (n >= 650 && $urandom_range(0, 119) == 0))
                send_beat(mtwg_pkg::OP_RESEED, $urandom());
            else
                send_beat(mtwg_pkg::OP_DRAW, $urandom());
            sender_gap();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (words_pending == 0);
        // a trailing reseed may still be running; any stray word gets caught
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d beats sent: %0d words checked, %0d reseeds, %0d table regenerations",
                 beats_sent, words_checked, reseed_count, regen_count);
        $display("stalls on both sides, one long output hold-off and one drain pause");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
